@@ src/ptm_pkg.sv @@
// ----------------------------------------------------------------------------
// Temporal median package
// Shared types and defaults for the per-pixel temporal median core and its
// sorting cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

  // Default capacity of the sorted row, in samples.
  localparam int MAX_SAMPLES_DEF = 32;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;

  // Channel positions within a pixel.
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CHAN-1:0] pixel_t;
  typedef logic [NUM_CHAN-1:0] chan_flags_t;

  // Control that every cell of the row receives for one insertion.
  typedef struct packed {
    logic ins_en;  // a sample is being inserted this cycle
    logic active;  // this cell holds a sample of the current pixel
    logic at_end;  // this cell is the first free one
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/ptm_cell.sv @@
// ----------------------------------------------------------------------------
// Temporal median sorting cell
// One position of the insertion-sorted row. It holds one byte per channel,
// compares it with the incoming sample and either keeps it, takes the value of
// its left neighbour, or takes the sample itself.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_cell (
  input  wire                    clk,
  input  ptm_pkg::cell_ctrl_t    ctrl,
  input  ptm_pkg::pixel_t        sample,
  input  ptm_pkg::pixel_t        prev_val,
  input  ptm_pkg::chan_flags_t   prev_gt,
  output ptm_pkg::pixel_t        val,
  output ptm_pkg::chan_flags_t   gt
);

  ptm_pkg::pixel_t val_next;

  always_comb begin
    for (int c = 0; c < ptm_pkg::NUM_CHAN; c++) begin
      gt[c] = ctrl.active && (val[c] > sample[c]);
    end
  end

  // The row is ascending, so the flags rise once from left to right: a cell
  // whose left neighbour is greater than the sample shifts right by one.
  always_comb begin
    for (int c = 0; c < ptm_pkg::NUM_CHAN; c++) begin
      if (prev_gt[c]) begin
        val_next[c] = prev_val[c];
      end else if (gt[c] || ctrl.at_end) begin
        val_next[c] = sample[c];
      end else begin
        val_next[c] = val[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins_en && (ctrl.active || ctrl.at_end)) begin
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

@@ src/per_pixel_temporal_median_core.sv @@
// ----------------------------------------------------------------------------
// Per-pixel temporal median core
// Gathers the blue, green and red bytes of one pixel over several frames in a
// row of insertion-sorting cells and emits the per-channel element at index
// count/2 once the marked last sample has been taken.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per cycle, with no gap between pixels, unless
//   a pending result held up by out_stall raises in_stall.
// Result: the last sample beat is inserted into the row, then the median is
//   selected from the row and registered into the output stage.
// Reset: clears the sample count, the overflow flag and both valid stages;
//   the cell contents are not cleared and are never read before being written.
`default_nettype none

module per_pixel_temporal_median_core #(
  parameter int MAX_SAMPLES = ptm_pkg::MAX_SAMPLES_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [7:0]           sample_blue,
  input  wire  [7:0]           sample_green,
  input  wire  [7:0]           sample_red,
  input  wire                  last_sample,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [7:0]           median_blue,
  output logic [7:0]           median_green,
  output logic [7:0]           median_red,
  output logic                 overflowed
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_after;
  logic             drop;
  logic             full;
  logic             in_fire;
  logic             ins;

  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic             pend_drop;
  logic             out_take;

  ptm_pkg::pixel_t      sample;
  ptm_pkg::pixel_t      cell_val [MAX_SAMPLES];
  ptm_pkg::chan_flags_t cell_gt  [MAX_SAMPLES];
  ptm_pkg::pixel_t      median;

  assign full     = (count == CNT_W'(MAX_SAMPLES));
  assign out_take = !out_valid || !out_stall;
  // The row must hold still while its pending result cannot move on.
  assign in_stall = pend_valid && !out_take;
  assign in_fire  = in_valid && !in_stall;
  assign ins      = in_fire && !full;

  assign count_after = ins ? count + CNT_W'(1) : count;

  always_comb begin
    sample = '0;
    sample[ptm_pkg::CH_BLUE]  = sample_blue;
    sample[ptm_pkg::CH_GREEN] = sample_green;
    sample[ptm_pkg::CH_RED]   = sample_red;
  end

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    ptm_pkg::cell_ctrl_t  ctrl;
    ptm_pkg::pixel_t      prev_val;
    ptm_pkg::chan_flags_t prev_gt;

    assign ctrl = '{ins_en: ins,
                    active: (CNT_W'(i) < count),
                    at_end: (CNT_W'(i) == count)};

    if (i == 0) begin : g_first
      assign prev_val = '0;
      assign prev_gt  = '0;
    end else begin : g_rest
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    ptm_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .sample   (sample),
      .prev_val (prev_val),
      .prev_gt  (prev_gt),
      .val      (cell_val[i]),
      .gt       (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (in_fire && last_sample) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (in_fire) begin
      count <= count_after;
      if (full) begin
        drop <= 1'b1;
      end
    end
  end

  // The median is read from the row once the pending result can move on; a new
  // pixel may insert in that same cycle since the read sees the old contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire && last_sample) begin
      pend_valid <= 1'b1;
    end else if (out_take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_sample) begin
      pend_idx  <= IDX_W'(count_after >> 1);
      pend_drop <= drop || full;
    end
  end

  assign median = cell_val[pend_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && pend_valid) begin
      median_blue  <= median[ptm_pkg::CH_BLUE];
      median_green <= median[ptm_pkg::CH_GREEN];
      median_red   <= median[ptm_pkg::CH_RED];
      overflowed   <= pend_drop;
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_per_pixel_temporal_median_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the per-pixel temporal median core
// Feeds pixels of one to a few dozen frame samples, some past capacity,
// through the sample channel with random gaps and result stalls. A running
// sorted-row model of the core predicts each unplanned median beat, and every
// result beat is compared in order with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_per_pixel_temporal_median_core;

  localparam int CAPACITY     = ptm_pkg::MAX_SAMPLES_DEF;
  localparam int RANDOM_BEATS = 680;

  typedef struct packed {
    ptm_pkg::chan_t blue;
    ptm_pkg::chan_t green;
    ptm_pkg::chan_t red;
    logic           dropped;
  } median_t;

  typedef struct {
    ptm_pkg::chan_t blue;
    ptm_pkg::chan_t green;
    ptm_pkg::chan_t red;
    logic           last;
    int             reps;
    logic           typed;
    median_t        want;
  } plan_row_t;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  ptm_pkg::chan_t sample_blue;
  ptm_pkg::chan_t sample_green;
  ptm_pkg::chan_t sample_red;
  logic           last_sample;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ptm_pkg::chan_t median_blue;
  ptm_pkg::chan_t median_green;
  ptm_pkg::chan_t median_red;
  logic           overflowed;

  // Sorted rows of the pixel being gathered, one per channel.
  ptm_pkg::chan_t sorted_rows [ptm_pkg::NUM_CHAN][CAPACITY];
  int             held_samples;
  logic           drop_seen;
  median_t        median_q[$];

  int   beats_sent;
  int   errors;
  logic tx_calm;
  int   rx_hold = 0;
  logic rx_calm = 1'b0;

  per_pixel_temporal_median_core #(
    .MAX_SAMPLES(CAPACITY)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_blue (sample_blue),
    .sample_green(sample_green),
    .sample_red  (sample_red),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .median_blue (median_blue),
    .median_green(median_green),
    .median_red  (median_red),
    .overflowed  (overflowed)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Inserts one sample into the sorted rows; on the marked sample it yields
  // the element at index count/2 of each row and clears for the next pixel.
  task automatic track_sample(input ptm_pkg::pixel_t px, input logic last,
                              output logic done, output median_t med);
    int p;
    int mid;
    if (held_samples < CAPACITY) begin
      for (int c = 0; c < ptm_pkg::NUM_CHAN; c++) begin
        p = held_samples;
        while (p > 0 && sorted_rows[c][p-1] > px[c]) begin
          sorted_rows[c][p] = sorted_rows[c][p-1];
          p--;
        end
        sorted_rows[c][p] = px[c];
      end
      held_samples++;
    end else begin
      drop_seen = 1'b1;
    end
    done = last;
    med  = '0;
    if (last) begin
      mid = held_samples / 2;
      if (mid >= CAPACITY) begin
        mid = CAPACITY - 1;
      end
      med.blue     = sorted_rows[ptm_pkg::CH_BLUE][mid];
      med.green    = sorted_rows[ptm_pkg::CH_GREEN][mid];
      med.red      = sorted_rows[ptm_pkg::CH_RED][mid];
      med.dropped  = drop_seen;
      held_samples = 0;
      drop_seen    = 1'b0;
    end
  endtask

  task automatic send_sample(input ptm_pkg::pixel_t px, input logic last,
                             input logic typed, input median_t want);
    int      gap;
    logic    done;
    median_t med;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    sample_blue  <= px[ptm_pkg::CH_BLUE];
    sample_green <= px[ptm_pkg::CH_GREEN];
    sample_red   <= px[ptm_pkg::CH_RED];
    last_sample  <= last;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    track_sample(px, last, done, med);
    if (done) begin
      median_q.insert(median_q.size(), typed ? want : med);
    end
    if ($urandom_range(0, 31) == 0) begin
      tx_calm = !tx_calm;
    end
  endtask

  // Holds the sample channel idle until every predicted median has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
  endtask

  function automatic ptm_pkg::chan_t draw_chan(input int flavour);
    case (flavour)
      0:       return ptm_pkg::chan_t'($urandom_range(0, 255));
      1:       return ptm_pkg::chan_t'($urandom_range(120, 135));
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  always @(posedge clk) begin
    median_t want;
    median_t got;
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
    end
    if (!rst && out_valid && !out_stall) begin
      got = '{median_blue, median_green, median_red, overflowed};
      if (median_q.size() == 0) begin
        $display("%0t: result beat with none pending, got b=%h g=%h r=%h ovf=%b",
                 $time, got.blue, got.green, got.red, got.dropped);
        errors++;
      end else begin
        want = median_q.pop_front();
        if (got !== want) begin
          $display({"%0t: median mismatch, expected b=%h g=%h r=%h ovf=%b, ",
                    "got b=%h g=%h r=%h ovf=%b"},
                   $time, want.blue, want.green, want.red, want.dropped,
                   got.blue, got.green, got.red, got.dropped);
          errors++;
        end
      end
      rx_hold = rx_calm ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) begin
        rx_calm = !rx_calm;
      end
    end
  end

  // Stalls after each result beat as drawn, plus the odd stray stall.
  always @(negedge clk) begin
    out_stall <= (rx_hold != 0) || (!rx_calm && $urandom_range(0, 3) == 0);
  end

  initial begin
    plan_row_t       plan [13];
    ptm_pkg::pixel_t px;
    logic            last_now;
    int              rnd_start;
    int              len;
    int              pick;
    int              flavour;
    logic            paused;

    rst          = 1'b1;
    in_valid     = 1'b0;
    sample_blue  = '0;
    sample_green = '0;
    sample_red   = '0;
    last_sample  = 1'b0;
    held_samples = 0;
    drop_seen    = 1'b0;
    beats_sent   = 0;
    errors       = 0;
    tx_calm      = 1'b0;
    paused       = 1'b0;

    // Single-sample pixels give back the sample itself.
    plan[0]  = '{8'h00, 8'h00, 8'h00, 1'b1, 1, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}};
    plan[1]  = '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}};
    plan[2]  = '{8'hA5, 8'h5A, 8'h3C, 1'b1, 1, 1'b1, '{8'hA5, 8'h5A, 8'h3C, 1'b0}};
    // Even count picks the upper median, then an odd count picks the middle one.
    plan[3]  = '{8'h10, 8'h20, 8'h30, 1'b0, 1, 1'b0, '0};
    plan[4]  = '{8'h40, 8'h05, 8'h30, 1'b1, 1, 1'b0, '0};
    plan[5]  = '{8'hFF, 8'h00, 8'h80, 1'b0, 1, 1'b0, '0};
    plan[6]  = '{8'h00, 8'hFF, 8'h80, 1'b0, 1, 1'b0, '0};
    plan[7]  = '{8'h7F, 8'h80, 8'h01, 1'b1, 1, 1'b0, '0};
    // Exactly full row, no drop.
    plan[8]  = '{8'hC3, 8'h3C, 8'h99, 1'b0, CAPACITY - 1, 1'b0, '0};
    plan[9]  = '{8'h00, 8'hFF, 8'h00, 1'b1, 1, 1'b0, '0};
    // Full row, then a marked sample that is dropped but still ends the pixel.
    plan[10] = '{8'h11, 8'h22, 8'h33, 1'b0, CAPACITY, 1'b0, '0};
    plan[11] = '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1, 1'b1, '{8'h11, 8'h22, 8'h33, 1'b1}};
    // The drop flag must not carry into the next pixel.
    plan[12] = '{8'h01, 8'h02, 8'h04, 1'b1, 1, 1'b1, '{8'h01, 8'h02, 8'h04, 1'b0}};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        px[ptm_pkg::CH_BLUE]  = plan[i].blue;
        px[ptm_pkg::CH_GREEN] = plan[i].green;
        px[ptm_pkg::CH_RED]   = plan[i].red;
        last_now              = plan[i].last && (k == plan[i].reps - 1);
        send_sample(px, last_now, plan[i].typed && last_now, plan[i].want);
      end
    end
    drain_results();

    rnd_start = beats_sent;
    while (beats_sent - rnd_start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 8);
      end else if (pick < 90) begin
        len = $urandom_range(9, CAPACITY);
      end else begin
        len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      end
      flavour = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        px[ptm_pkg::CH_BLUE]  = draw_chan(flavour);
        px[ptm_pkg::CH_GREEN] = draw_chan(flavour);
        px[ptm_pkg::CH_RED]   = draw_chan(flavour);
        send_sample(px, k == len - 1, 1'b0, '0);
      end
      if (!paused && beats_sent - rnd_start > RANDOM_BEATS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
